/* design/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and controller/datapath interface types for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int WORD_BITS_DEF = 16;
    localparam int CFG_ADDR_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_EXPONENT = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MODULUS  = 2'd1;

    // modular multiplier operations
    typedef enum logic [1:0] {
        MOP_NONE   = 2'd0,
        MOP_REDUCE = 2'd1,
        MOP_SQUARE = 2'd2,
        MOP_MULT   = 2'd3
    } mop_t;

    typedef struct packed {
        mop_t op;
        logic shift_exp;
        logic emit;
    } mexp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic exp_bit;
    } mexp_stat_t;

endpackage

/* design/mexp_dp.sv */
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: key registers, base and accumulator, bit-serial interleaved
// modular multiplier, exponent shifter and result register.
// ----------------------------------------------------------------------------
module mexp_dp #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF,
    localparam int CNT_W = $clog2(WORD_BITS)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [mexp_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [WORD_BITS-1:0]               cfg_wdata,
    input  logic [WORD_BITS-1:0]               in_msg,
    input  mexp_pkg::mexp_cmd_t                cmd,
    output mexp_pkg::mexp_stat_t               stat,
    output logic [WORD_BITS-1:0]               result
);

    logic [WORD_BITS-1:0] exp_reg, mod_reg;
    logic [WORD_BITS-1:0] base_reg, acc_reg, result_reg, exp_sh_reg;
    logic [WORD_BITS-1:0] a_reg, b_reg, r_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg, dst_base_reg;

    logic [WORD_BITS:0]   n_w, t0, t1, t2, t3, addend;
    logic [WORD_BITS-1:0] r_next;
    logic                 mul_last;

    // one multiplier bit per cycle: r = 2r + b_msb*a, kept below n
    always_comb begin
        n_w    = {1'b0, mod_reg};
        t0     = {r_reg, 1'b0};
        t1     = (t0 >= n_w) ? (t0 - n_w) : t0;
        addend = b_reg[WORD_BITS-1] ? {1'b0, a_reg} : '0;
        t2     = t1 + addend;
        t3     = (t2 >= n_w) ? (t2 - n_w) : t2;
        r_next = t3[WORD_BITS-1:0];
    end

    assign mul_last = busy_reg && (cnt_reg == CNT_W'(WORD_BITS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg  <= WORD_BITS'(1);
            mod_reg  <= '1;
            busy_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    mexp_pkg::REG_EXPONENT: exp_reg <= cfg_wdata;
                    mexp_pkg::REG_MODULUS:  mod_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.op != mexp_pkg::MOP_NONE) begin
                busy_reg <= 1'b1;
            end else if (mul_last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            mexp_pkg::MOP_REDUCE: begin
                // message mod n, with accumulator preset to 1 mod n
                a_reg      <= WORD_BITS'(1);
                b_reg      <= in_msg;
                acc_reg    <= (mod_reg == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
                exp_sh_reg <= exp_reg;
            end
            mexp_pkg::MOP_SQUARE: begin
                a_reg <= acc_reg;
                b_reg <= acc_reg;
            end
            mexp_pkg::MOP_MULT: begin
                a_reg <= base_reg;
                b_reg <= acc_reg;
            end
            default: begin
                if (busy_reg) begin
                    b_reg <= {b_reg[WORD_BITS-2:0], 1'b0};
                end
            end
        endcase

        if (cmd.op != mexp_pkg::MOP_NONE) begin
            r_reg        <= '0;
            cnt_reg      <= '0;
            dst_base_reg <= (cmd.op == mexp_pkg::MOP_REDUCE);
        end else if (busy_reg) begin
            r_reg   <= r_next;
            cnt_reg <= cnt_reg + 1'b1;
        end

        if (mul_last) begin
            if (dst_base_reg) begin
                base_reg <= r_next;
            end else begin
                acc_reg <= r_next;
            end
        end

        if (cmd.shift_exp) begin
            exp_sh_reg <= {exp_sh_reg[WORD_BITS-2:0], 1'b0};
        end

        // a zero modulus has no residue: report 0
        if (cmd.emit) begin
            result_reg <= (mod_reg == '0) ? '0 : acc_reg;
        end
    end

    assign stat.mul_done = mul_last;
    assign stat.exp_bit  = exp_sh_reg[WORD_BITS-1];
    assign result        = result_reg;

endmodule

/* design/mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: sequences reduction, square and conditional multiply over the
// exponent bits, and owns both stream handshakes.
// ----------------------------------------------------------------------------
module mexp_ctrl #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF,
    localparam int CNT_W = $clog2(WORD_BITS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  mexp_pkg::mexp_stat_t stat,
    output mexp_pkg::mexp_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_RED_WAIT = 7'b0000010,
        ST_SQ_START = 7'b0000100,
        ST_SQ_WAIT  = 7'b0001000,
        ST_MU_CHECK = 7'b0010000,
        ST_MU_WAIT  = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             advance;

    always_comb begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        cmd          = '0;
        cmd.op       = mexp_pkg::MOP_NONE;
        s_tready     = 1'b0;
        advance      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op       = mexp_pkg::MOP_REDUCE;
                    bit_cnt_next = CNT_W'(WORD_BITS - 1);
                    state_next   = ST_RED_WAIT;
                end
            end
            ST_RED_WAIT: begin
                if (stat.mul_done) begin
                    state_next = ST_SQ_START;
                end
            end
            ST_SQ_START: begin
                cmd.op     = mexp_pkg::MOP_SQUARE;
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (stat.mul_done) begin
                    state_next = ST_MU_CHECK;
                end
            end
            ST_MU_CHECK: begin
                if (stat.exp_bit) begin
                    cmd.op     = mexp_pkg::MOP_MULT;
                    state_next = ST_MU_WAIT;
                end else begin
                    advance = 1'b1;
                end
            end
            ST_MU_WAIT: begin
                advance = stat.mul_done;
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance) begin
            cmd.shift_exp = 1'b1;
            if (bit_cnt_reg == '0) begin
                state_next = ST_FINISH;
            end else begin
                bit_cnt_next = bit_cnt_reg - 1'b1;
                state_next   = ST_SQ_START;
            end
        end

        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

/* design/modular_exponentiation_top.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Raises each message word to the configured exponent modulo the configured
// modulus using left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
// Operation: one reduction of the message, then per exponent bit a square and,
//   for a set bit, a multiply, each done by the bit-serial modular multiplier.
// Throughput: a new word is accepted only once the previous result has been
//   written to the output register; the bit-serial modular multiplier sets the pace.
// Reset: synchronous active-low aresetn loads exponent = 1, modulus = all ones
//   and empties the output register.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF,
    localparam int TDATA_W = ((WORD_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [mexp_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [WORD_BITS-1:0]               cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [TDATA_W-1:0]                 s_tdata,  // message
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [TDATA_W-1:0]                 m_tdata   // result
);

    mexp_pkg::mexp_cmd_t  cmd;
    mexp_pkg::mexp_stat_t stat;
    logic [WORD_BITS-1:0] result;

    mexp_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mexp_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_msg    (s_tdata[WORD_BITS-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

    assign m_tdata = TDATA_W'(result);

endmodule

/* design/mexp_checker.sv */
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks for the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
module mexp_checker #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF,
    parameter int TDATA_W = ((WORD_BITS + 7) / 8) * 8
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a residue is always below the modulus, so never all ones
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[WORD_BITS-1:0] != {WORD_BITS{1'b1}}))
        else $error("result not reduced");

    // one word at a time: busy right after accepting a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in progress");

endmodule

bind modular_exponentiation_top mexp_checker #(
    .WORD_BITS (WORD_BITS),
    .TDATA_W   (TDATA_W)
) u_mexp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
